@@ sv/slln_pkg.sv @@
// Package for the sweep listen link node controller.
// Holds field widths, request, mode, register index and sequencer codes.
// No dependencies; every other file but slln_ram imports it.
package slln_pkg;

  // Field widths
  localparam int REQ_W      = 3;
  localparam int TIME_W     = 32;
  localparam int FREQ_W     = 16;
  localparam int AMP_W      = 16;
  localparam int SEL_W      = 2;
  localparam int ENERGY_W   = 32;
  localparam int TONE_W     = 16;
  localparam int CNT_OUT_W  = 5;
  localparam int FLAG_W     = 4;
  localparam int MINB_W     = 5;
  localparam int MS_W       = 16;
  localparam int TOL_W      = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Gap between low and high tone
  localparam logic [TONE_W-1:0] TONE_GAP_HZ = 16'd200;

  // Register reset values
  localparam logic [MINB_W-1:0] MIN_BINS_RST  = 5'd5;
  localparam logic [MS_W-1:0]   SESSION_RST   = 16'd850;
  localparam logic [MS_W-1:0]   CHECK_PER_RST = 16'd40;
  localparam logic [TOL_W-1:0]  TOL_RST       = 5'd15;

  // Request codes; the two unused codes only report status
  typedef enum logic [REQ_W-1:0] {
    REQ_TICK     = 3'd0,
    REQ_HIT      = 3'd1,
    REQ_FLAG_SET = 3'd2,
    REQ_FLAG_CLR = 3'd3,
    REQ_QUIET    = 3'd4,
    REQ_FAULT    = 3'd5
  } req_type_t;

  // Node modes
  typedef enum logic [1:0] {
    MODE_LISTEN  = 2'd0,
    MODE_PRELINK = 2'd1,
    MODE_SLEEP   = 2'd2,
    MODE_FAULT   = 2'd3
  } mode_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIGNAL_THRESHOLD = 3'd0,
    CFG_MIN_VALID_BINS   = 3'd1,
    CFG_SESSION_MS       = 3'd2,
    CFG_CHECK_PERIOD_MS  = 3'd3,
    CFG_TOLERANCE_HZ     = 3'd4
  } cfg_idx_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_BIN,
    ST_RMW,
    ST_SCAN,
    ST_SETTLE,
    ST_DONE
  } fsm_t;

endpackage

@@ sv/slln_in_if.sv @@
// Event channel: valid/ready handshake carrying one request beat.
// Depends on slln_pkg for field widths.
interface slln_in_if
  import slln_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [TIME_W-1:0]   now_ms;
  logic [FREQ_W-1:0]   hit_freq_hz;
  logic [AMP_W-1:0]    hit_amplitude;
  logic [SEL_W-1:0]    flag_select;
  logic [ENERGY_W-1:0] bus_energy;

  modport source (
    output valid, req_type, now_ms, hit_freq_hz, hit_amplitude, flag_select, bus_energy,
    input  ready
  );
  modport sink (
    input  valid, req_type, now_ms, hit_freq_hz, hit_amplitude, flag_select, bus_energy,
    output ready
  );
endinterface

@@ sv/slln_out_if.sv @@
// Status channel: valid/ready handshake carrying one status beat.
// Depends on slln_pkg for field widths and the mode type.
interface slln_out_if
  import slln_pkg::*;
();
  logic                 valid;
  logic                 ready;
  mode_t                node_mode;
  logic [TONE_W-1:0]    pair_low_hz;
  logic [TONE_W-1:0]    pair_high_hz;
  logic                 pair_locked;
  logic                 all_flags_clear;
  logic                 settled;
  logic [CNT_OUT_W-1:0] settled_count;

  modport source (
    output valid, node_mode, pair_low_hz, pair_high_hz, pair_locked, all_flags_clear,
           settled, settled_count,
    input  ready
  );
  modport sink (
    input  valid, node_mode, pair_low_hz, pair_high_hz, pair_locked, all_flags_clear,
           settled, settled_count,
    output ready
  );
endinterface

@@ sv/slln_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package dependency.
module slln_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 19
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/sweep_listen_link_node_fsm_core.sv @@
// Top level of the sweep listen link node controller: sequencer, peak table RAM.
// Depends on slln_pkg, slln_in_if, slln_out_if and slln_ram.
//
//   channel  | direction | handshake     | beat
//   ---------+-----------+---------------+------------------------------------------
//   in_bus   | in        | valid/ready   | req_type, now_ms, hit fields, flag, energy
//   out_bus  | out       | valid/ready   | mode, tone pair, lock, flags clear, settle
//   cfg_*    | in        | write enable  | register index, write data
//
// One event beat is handled at a time. Flag, quiet, fault, ignored hits and most
// ticks go from accept through the execute step to the status step; a sweep hit in
// the bin range first divides its offset by the bin step, by reciprocal
// multiplication for the quotient and then a step for the remainder, then does a
// read-modify-write of the peak table (skipped when it misses the tolerance). A
// settling tick scans the peak table RAM at one read per cycle before it settles.
// A new event is accepted while the previous result still waits in the output
// register; the sequencer stalls at its last step until that register frees up.
// Reset is synchronous, active low; the peak table needs no clearing pass since
// each entry carries a valid bit that reset and a return to listen clear at once.
module sweep_listen_link_node_fsm_core
  import slln_pkg::*;
#(
  parameter int BASE_FREQ_HZ = 125,
  parameter int BIN_STEP_HZ  = 50,
  parameter int BIN_COUNT    = 19
) (
  input  logic                  clk,
  input  logic                  rst_n,
  slln_in_if.sink               in_bus,
  slln_out_if.source            out_bus,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW    = $clog2(BIN_COUNT);
  localparam int CW    = $clog2(BIN_COUNT + 1);
  localparam int DLT_W = FREQ_W + 1;
  localparam int SPAN  = BIN_COUNT * BIN_STEP_HZ;
  localparam int HALF  = BIN_STEP_HZ / 2;
  localparam int FQ_W  = $clog2(BASE_FREQ_HZ + BIN_COUNT * BIN_STEP_HZ + 1);
  localparam int CMP_W = (CW > MINB_W) ? CW : MINB_W;
  // Reciprocal of the bin step, exact for every 16-bit offset
  localparam int DIV_SH = FREQ_W + $clog2(BIN_STEP_HZ);
  localparam int DIV_MW = FREQ_W + 2;
  localparam int PROD_W = DLT_W + DIV_MW;
  localparam logic [DIV_MW-1:0] DIV_MUL =
    DIV_MW'(((64'd1 << DIV_SH) + 64'(BIN_STEP_HZ) - 64'd1) / 64'(BIN_STEP_HZ));

  // Configuration registers
  logic [ENERGY_W-1:0] thresh_r;
  logic [MINB_W-1:0]   min_bins_r;
  logic [MS_W-1:0]     session_ms_r;
  logic [MS_W-1:0]     check_ms_r;
  logic [TOL_W-1:0]    tol_r;

  // Node state
  fsm_t                state_r, state_nxt;
  mode_t               mode_r, mode_nxt;
  logic [BIN_COUNT-1:0] bin_vld_r, bin_vld_nxt;
  logic                armed_r, armed_nxt;
  logic [TIME_W-1:0]   sess_start_r, sess_start_nxt;
  logic [TIME_W-1:0]   last_check_r, last_check_nxt;
  logic [TONE_W-1:0]   tone_low_r, tone_low_nxt;
  logic [TONE_W-1:0]   tone_high_r, tone_high_nxt;
  logic [FLAG_W-1:0]   flags_r, flags_nxt;

  // Captured event
  logic [REQ_W-1:0]    req_r, req_nxt;
  logic [TIME_W-1:0]   now_r, now_nxt;
  logic [FREQ_W-1:0]   freq_r, freq_nxt;
  logic [AMP_W-1:0]    amp_r, amp_nxt;
  logic [SEL_W-1:0]    sel_r, sel_nxt;
  logic [ENERGY_W-1:0] energy_r, energy_nxt;

  // Work registers
  logic [CW-1:0]       step_r, step_nxt;
  logic [DLT_W-1:0]    rem_r, rem_nxt;
  logic [AW-1:0]       quo_r, quo_nxt;
  logic [AW-1:0]       hit_bin_r, hit_bin_nxt;
  logic                rd_ok_r, rd_ok_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [AMP_W-1:0]    best_r, best_nxt;
  logic [FQ_W-1:0]     f0_r, f0_nxt;
  logic [FQ_W-1:0]     scan_freq_r, scan_freq_nxt;
  logic                settled_r, settled_nxt;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  mode_t               o_mode_r, o_mode_nxt;
  logic [TONE_W-1:0]   o_low_r, o_low_nxt;
  logic [TONE_W-1:0]   o_high_r, o_high_nxt;
  logic                o_locked_r, o_locked_nxt;
  logic                o_clear_r, o_clear_nxt;
  logic                o_settled_r, o_settled_nxt;
  logic [CNT_OUT_W-1:0] o_count_r, o_count_nxt;

  // RAM port
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [AMP_W-1:0]    ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [AMP_W-1:0]    ram_rdata;

  // Decoded conditions
  logic                in_acc;
  logic                is_listen;
  logic                hit_low;
  logic [FREQ_W-1:0]   hit_delta;
  logic                hit_span;
  logic                hit_start;
  logic                sess_due;
  logic                scan_start;
  logic                div_last;
  logic [PROD_W-1:0]   div_prod;
  logic                rnd;
  logic [AW:0]         idx_w;
  logic [DLT_W-1:0]    off_w;
  logic                bin_ok;
  logic                scan_rd;
  logic                scan_last;
  logic                out_free;
  logic [AMP_W-1:0]    eff_rd;
  logic                go_en;
  mode_t               go_to;

  // Peak table storage; the valid bits stand for the all-zero reset value
  slln_ram #(
    .WIDTH (AMP_W),
    .DEPTH (BIN_COUNT)
  ) u_peak_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Handshake ports
  assign in_bus.ready          = (state_r == ST_IDLE);
  assign in_acc                = in_bus.valid && in_bus.ready;
  assign out_bus.valid         = out_valid_r;
  assign out_bus.node_mode     = o_mode_r;
  assign out_bus.pair_low_hz   = o_low_r;
  assign out_bus.pair_high_hz  = o_high_r;
  assign out_bus.pair_locked   = o_locked_r;
  assign out_bus.all_flags_clear = o_clear_r;
  assign out_bus.settled       = o_settled_r;
  assign out_bus.settled_count = o_count_r;

  // Decode conditions shared by next-state and datapath
  always_comb begin
    is_listen  = (mode_r == MODE_LISTEN);
    hit_low    = ({1'b0, freq_r} + DLT_W'(tol_r)) < DLT_W'(BASE_FREQ_HZ);
    hit_delta  = (freq_r >= FREQ_W'(BASE_FREQ_HZ)) ? (freq_r - FREQ_W'(BASE_FREQ_HZ)) : '0;
    hit_span   = {1'b0, hit_delta} >= DLT_W'(SPAN);
    hit_start  = (req_r == REQ_HIT) && is_listen && !hit_low && !hit_span;
    sess_due   = (now_r - sess_start_r) >= TIME_W'(session_ms_r);
    scan_start = (req_r == REQ_TICK) && is_listen && armed_r && sess_due;
    div_last   = (step_r == CW'(1));
    div_prod   = rem_r * DIV_MUL;
    rnd        = rem_r > DLT_W'(HALF);
    idx_w      = (AW + 1)'(quo_r) + (AW + 1)'(rnd);
    off_w      = rnd ? (DLT_W'(BIN_STEP_HZ) - rem_r) : rem_r;
    bin_ok     = (idx_w < (AW + 1)'(BIN_COUNT)) && (off_w <= DLT_W'(tol_r));
    scan_rd    = (step_r < CW'(BIN_COUNT));
    scan_last  = (step_r == CW'(BIN_COUNT));
    out_free   = !out_valid_r || out_bus.ready;
    eff_rd     = rd_ok_r ? ram_rdata : '0;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_acc) state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (hit_start) begin
          state_nxt = ST_DIV;
        end else if (scan_start) begin
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DIV:    if (div_last) state_nxt = ST_BIN;
      ST_BIN:    state_nxt = bin_ok ? ST_RMW : ST_DONE;
      ST_RMW:    state_nxt = ST_DONE;
      ST_SCAN:   if (scan_last) state_nxt = ST_SETTLE;
      ST_SETTLE: state_nxt = ST_DONE;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and RAM control per state
  always_comb begin
    mode_nxt       = mode_r;
    bin_vld_nxt    = bin_vld_r;
    armed_nxt      = armed_r;
    sess_start_nxt = sess_start_r;
    last_check_nxt = last_check_r;
    tone_low_nxt   = tone_low_r;
    tone_high_nxt  = tone_high_r;
    flags_nxt      = flags_r;
    req_nxt        = req_r;
    now_nxt        = now_r;
    freq_nxt       = freq_r;
    amp_nxt        = amp_r;
    sel_nxt        = sel_r;
    energy_nxt     = energy_r;
    step_nxt       = step_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    hit_bin_nxt    = hit_bin_r;
    rd_ok_nxt      = rd_ok_r;
    cnt_nxt        = cnt_r;
    best_nxt       = best_r;
    f0_nxt         = f0_r;
    scan_freq_nxt  = scan_freq_r;
    settled_nxt    = settled_r;
    out_valid_nxt  = out_valid_r;
    o_mode_nxt     = o_mode_r;
    o_low_nxt      = o_low_r;
    o_high_nxt     = o_high_r;
    o_locked_nxt   = o_locked_r;
    o_clear_nxt    = o_clear_r;
    o_settled_nxt  = o_settled_r;
    o_count_nxt    = o_count_r;
    ram_we         = 1'b0;
    ram_waddr      = hit_bin_r;
    ram_wdata      = amp_r;
    ram_re         = 1'b0;
    ram_raddr      = step_r[AW-1:0];
    go_en          = 1'b0;
    go_to          = mode_r;

    // Drop the output beat once taken
    if (out_valid_r && out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        // Capture the event beat
        if (in_acc) begin
          req_nxt     = in_bus.req_type;
          now_nxt     = in_bus.now_ms;
          freq_nxt    = in_bus.hit_freq_hz;
          amp_nxt     = in_bus.hit_amplitude;
          sel_nxt     = in_bus.flag_select;
          energy_nxt  = in_bus.bus_energy;
          settled_nxt = 1'b0;
          cnt_nxt     = '0;
        end
      end
      ST_EXEC: begin
        case (req_r)
          REQ_TICK: begin
            if (is_listen) begin
              if (scan_start) begin
                step_nxt      = '0;
                cnt_nxt       = '0;
                best_nxt      = '0;
                f0_nxt        = '0;
                scan_freq_nxt = FQ_W'(BASE_FREQ_HZ);
              end
            end else if (mode_r == MODE_PRELINK) begin
              // Periodic bus energy check; a reply drops the tones
              if ((now_r - last_check_r) >= TIME_W'(check_ms_r)) begin
                last_check_nxt = now_r;
                if (energy_r > thresh_r) begin
                  tone_low_nxt  = '0;
                  tone_high_nxt = '0;
                  go_en         = 1'b1;
                  go_to         = MODE_LISTEN;
                end
              end
            end else if (mode_r == MODE_SLEEP) begin
              if (flags_r != '0) begin
                go_en = 1'b1;
                go_to = MODE_LISTEN;
              end
            end
          end
          REQ_HIT: begin
            // Start the bin division on the offset from the first bin
            if (hit_start) begin
              rem_nxt  = {1'b0, hit_delta};
              quo_nxt  = '0;
              step_nxt = '0;
            end
          end
          REQ_FLAG_SET: flags_nxt = flags_r | (FLAG_W'(1) << sel_r);
          REQ_FLAG_CLR: flags_nxt = flags_r & ~(FLAG_W'(1) << sel_r);
          REQ_QUIET: begin
            go_en = 1'b1;
            go_to = (flags_r == '0) ? MODE_SLEEP : MODE_LISTEN;
          end
          REQ_FAULT: begin
            go_en = 1'b1;
            go_to = MODE_FAULT;
          end
          default: ;
        endcase
      end
      ST_DIV: begin
        // Quotient by reciprocal multiply, then the remainder
        if (step_r == '0) begin
          quo_nxt = AW'(div_prod >> DIV_SH);
        end else begin
          rem_nxt = rem_r - DLT_W'(quo_r) * DLT_W'(BIN_STEP_HZ);
        end
        step_nxt = step_r + CW'(1);
      end
      ST_BIN: begin
        // Round to the nearest bin, then fetch its peak
        if (bin_ok) begin
          ram_re      = 1'b1;
          ram_raddr   = idx_w[AW-1:0];
          rd_ok_nxt   = bin_vld_r[idx_w[AW-1:0]];
          hit_bin_nxt = idx_w[AW-1:0];
          if (!armed_r) begin
            armed_nxt      = 1'b1;
            sess_start_nxt = now_r;
          end
        end
      end
      ST_RMW: begin
        // Keep the larger amplitude
        if (amp_r > eff_rd) begin
          ram_we                 = 1'b1;
          bin_vld_nxt[hit_bin_r] = 1'b1;
        end
      end
      ST_SCAN: begin
        // Issue read of bin step_r, process data of bin step_r - 1
        if (scan_rd) begin
          ram_re    = 1'b1;
          rd_ok_nxt = bin_vld_r[step_r[AW-1:0]];
        end
        if (step_r != '0) begin
          if (eff_rd != '0) begin
            cnt_nxt = cnt_r + CW'(1);
          end
          if (eff_rd > best_r) begin
            best_nxt = eff_rd;
            f0_nxt   = scan_freq_r;
          end
          scan_freq_nxt = scan_freq_r + FQ_W'(BIN_STEP_HZ);
        end
        step_nxt = step_r + CW'(1);
      end
      ST_SETTLE: begin
        // Close the session; enough bins pick the tone pair
        settled_nxt    = 1'b1;
        armed_nxt      = 1'b0;
        sess_start_nxt = '0;
        if (CMP_W'(cnt_r) >= CMP_W'(min_bins_r)) begin
          tone_low_nxt  = TONE_W'(f0_r);
          tone_high_nxt = TONE_W'(f0_r) + TONE_GAP_HZ;
          go_en         = 1'b1;
          go_to         = MODE_PRELINK;
        end
      end
      ST_DONE: begin
        // Load the status beat once the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_mode_nxt    = mode_r;
          o_low_nxt     = tone_low_r;
          o_high_nxt    = tone_high_r;
          o_locked_nxt  = (tone_low_r != '0);
          o_clear_nxt   = (flags_r == '0);
          o_settled_nxt = settled_r;
          o_count_nxt   = CNT_OUT_W'(cnt_r);
        end
      end
      default: ;
    endcase

    // Mode change; entering listen clears the table and disarms the session
    if (go_en && (go_to != mode_r)) begin
      mode_nxt = go_to;
      if (go_to == MODE_LISTEN) begin
        bin_vld_nxt    = '0;
        armed_nxt      = 1'b0;
        sess_start_nxt = '0;
      end else if (go_to == MODE_PRELINK) begin
        last_check_nxt = now_r;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r     <= '0;
      min_bins_r   <= MIN_BINS_RST;
      session_ms_r <= SESSION_RST;
      check_ms_r   <= CHECK_PER_RST;
      tol_r        <= TOL_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_SIGNAL_THRESHOLD: thresh_r     <= cfg_wdata[ENERGY_W-1:0];
        CFG_MIN_VALID_BINS:   min_bins_r   <= cfg_wdata[MINB_W-1:0];
        CFG_SESSION_MS:       session_ms_r <= cfg_wdata[MS_W-1:0];
        CFG_CHECK_PERIOD_MS:  check_ms_r   <= cfg_wdata[MS_W-1:0];
        CFG_TOLERANCE_HZ:     tol_r        <= cfg_wdata[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      mode_r       <= MODE_LISTEN;
      bin_vld_r    <= '0;
      armed_r      <= 1'b0;
      sess_start_r <= '0;
      last_check_r <= '0;
      tone_low_r   <= '0;
      tone_high_r  <= '0;
      flags_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mode_r       <= mode_nxt;
      bin_vld_r    <= bin_vld_nxt;
      armed_r      <= armed_nxt;
      sess_start_r <= sess_start_nxt;
      last_check_r <= last_check_nxt;
      tone_low_r   <= tone_low_nxt;
      tone_high_r  <= tone_high_nxt;
      flags_r      <= flags_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload and work registers
  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    now_r       <= now_nxt;
    freq_r      <= freq_nxt;
    amp_r       <= amp_nxt;
    sel_r       <= sel_nxt;
    energy_r    <= energy_nxt;
    step_r      <= step_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    hit_bin_r   <= hit_bin_nxt;
    rd_ok_r     <= rd_ok_nxt;
    cnt_r       <= cnt_nxt;
    best_r      <= best_nxt;
    f0_r        <= f0_nxt;
    scan_freq_r <= scan_freq_nxt;
    settled_r   <= settled_nxt;
    o_mode_r    <= o_mode_nxt;
    o_low_r     <= o_low_nxt;
    o_high_r    <= o_high_nxt;
    o_locked_r  <= o_locked_nxt;
    o_clear_r   <= o_clear_nxt;
    o_settled_r <= o_settled_nxt;
    o_count_r   <= o_count_nxt;
  end

  // Returning to listen leaves every bin empty
  a_listen_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(mode_r) != MODE_LISTEN) && (mode_r == MODE_LISTEN) |-> (bin_vld_r == '0))
    else $error("peak table not cleared on return to listen");

  // Pre-link always holds a tone pair spaced by the gap
  a_prelink_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_PRELINK) |-> (tone_high_r == TONE_W'(tone_low_r + TONE_GAP_HZ)))
    else $error("tone pair inconsistent in pre-link");

  // A beat that settles nothing reports no count
  a_count_only_settled: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && !out_bus.settled |-> (out_bus.settled_count == '0))
    else $error("count reported without settlement");

endmodule
